FILE: rtl/min_degree_elimination_order_top_macros.svh
// assertion macros for the minimum degree ordering block
// expects signals named clock and reset in the including scope
`ifndef MIN_DEGREE_ELIMINATION_ORDER_TOP_MACROS_SVH
`define MIN_DEGREE_ELIMINATION_ORDER_TOP_MACROS_SVH

// same-cycle implication
`define MDEO_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MDEO_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mdeo_pkg.sv
// shared types and constants of the minimum degree ordering block
// no dependencies
package mdeo_pkg;

   localparam int VTX_W       = 7;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 8;
   localparam int BYTE_CNT_W  = 4;

   localparam logic FUNC_ADD_EDGE = 1'b0;
   localparam logic FUNC_RUN      = 1'b1;

   // sequencer to degree unit
   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctrl_type;

   // degree unit back to sequencer
   typedef struct packed {
      logic busy;
      logic found;
   } scan_stat_type;

endpackage

FILE: rtl/min_degree_elimination_order_top.sv
// edge word: a legal edge reads and rewrites row a, then row b; an illegal one
// is dropped in idle. run word: per elimination a degree scan through the shared
// degree unit, then a fill-in update through the matrix ram port; afterwards
// each result word is read, loaded and sent, held while the output stalls
// reset clears the matrix valid bits (empty graph) and sets num_vertices to
// MAX_VERTICES; the matrix empties itself again at the end of every run
`include "min_degree_elimination_order_top_macros.svh"

module min_degree_elimination_order_top #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mdeo_pkg::REQ_TDATA_W-1:0]      req_tdata,   // vertex_a, vertex_b
   input  logic [0:0]                            req_tuser,   // func
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mdeo_pkg::RSP_TDATA_W-1:0]      rsp_tdata,   // vertex
   output logic                                  rsp_tlast,
   input  logic                                  csr_wr_en,
   input  logic [mdeo_pkg::VTX_W-1:0]            csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int VTX_W = mdeo_pkg::VTX_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EDGE_A,
      S_EDGE_B,
      S_SCAN,
      S_UPDATE,
      S_OUT_READ,
      S_OUT_LOAD,
      S_OUT_SEND
   } state_type;

   state_type                state_ff, state_in;
   logic [VTX_W-1:0]         num_vertices_ff;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [MAX_VERTICES-1:0]  active_ff, active_in;
   logic [MAX_VERTICES-1:0]  placed_ff, placed_in;
   logic [MAX_VERTICES-1:0]  nb_ff, nb_in;
   logic [MAX_VERTICES-1:0]  row_valid_ff, row_valid_in;
   logic [IDX_W-1:0]         best_ff, best_in;
   logic [IDX_W-1:0]         ia_ff, ia_in;
   logic [IDX_W-1:0]         ib_ff, ib_in;
   logic [CNT_W-1:0]         j_ff, j_in;
   logic [CNT_W-1:0]         k_ff, k_in;
   logic                     rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     rd_valid_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VTX_W-1:0]         rsp_vertex_ff, rsp_vertex_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]         n_eff;
   logic [MAX_VERTICES-1:0]  active_new;
   logic [VTX_W-1:0]         vertex_a, vertex_b;
   logic [VTX_W-1:0]         a_less, b_less;
   logic                     edge_ok;
   logic                     scan_done;
   logic [MAX_VERTICES-1:0]  row_q;
   logic [MAX_VERTICES-1:0]  vbit, ubit, vbit_new;
   logic [CNT_W-1:0]         out_src;

   logic                     adj_wr_en, adj_rd_en;
   logic [IDX_W-1:0]         adj_wr_addr, adj_rd_addr;
   logic [MAX_VERTICES-1:0]  adj_wr_data, adj_rd_data;
   logic                     ord_wr_en, ord_rd_en;
   logic [IDX_W-1:0]         ord_wr_addr, ord_rd_addr;
   logic [IDX_W-1:0]         ord_wr_data, ord_rd_data;

   mdeo_pkg::scan_ctrl_type  sc_ctrl;
   mdeo_pkg::scan_stat_type  sc_stat;
   logic [IDX_W-1:0]         sc_best_idx;
   logic [MAX_VERTICES-1:0]  sc_best_row;
   logic [MAX_VERTICES-1:0]  sc_row;

   mdeo_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_data),
      .rd_en   (adj_rd_en),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_data)
   );

   mdeo_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_wr_en),
      .wr_addr (ord_wr_addr),
      .wr_data (ord_wr_data),
      .rd_en   (ord_rd_en),
      .rd_addr (ord_rd_addr),
      .rd_data (ord_rd_data)
   );

   mdeo_scan_unit #(.MAX_VERTICES(MAX_VERTICES)) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (sc_ctrl),
      .idx      (rd_idx_ff),
      .row      (sc_row),
      .stat     (sc_stat),
      .best_idx (sc_best_idx),
      .best_row (sc_best_row)
   );

   // vertex count saturates at the matrix size
   always_comb begin
      if (num_vertices_ff > VTX_W'(MAX_VERTICES)) begin
         n_eff = CNT_W'(MAX_VERTICES);
      end else begin
         n_eff = num_vertices_ff[CNT_W-1:0];
      end
      for (int i = 0; i < MAX_VERTICES; i++) begin
         active_new[i] = (CNT_W'(i) < n_eff);
      end
   end

   assign vertex_a = req_tdata[VTX_W-1:0];
   assign vertex_b = req_tdata[2*VTX_W-1:VTX_W];
   assign a_less   = vertex_a - VTX_W'(1);
   assign b_less   = vertex_b - VTX_W'(1);
   assign edge_ok  = (vertex_a != '0) && (vertex_a <= VTX_W'(n_eff)) &&
                     (vertex_b != '0) && (vertex_b <= VTX_W'(n_eff)) &&
                     (vertex_a != vertex_b);

   // rows never written since the last clear read as empty
   assign row_q    = rd_valid_ff ? adj_rd_data : '0;
   assign vbit     = MAX_VERTICES'(1) << best_ff;
   assign ubit     = MAX_VERTICES'(1) << rd_idx_ff;
   assign vbit_new = MAX_VERTICES'(1) << sc_best_idx;
   assign sc_row   = row_q & active_ff & ~placed_ff;
   assign out_src  = n_ff - CNT_W'(1) - k_ff;
   assign scan_done = (j_ff >= n_ff) && !rd_pend_ff && !sc_stat.busy;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      active_in     = active_ff;
      placed_in     = placed_ff;
      nb_in         = nb_ff;
      row_valid_in  = row_valid_ff;
      best_in       = best_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      adj_wr_en     = 1'b0;
      adj_wr_addr   = rd_idx_ff;
      adj_wr_data   = '0;
      adj_rd_en     = 1'b0;
      adj_rd_addr   = j_ff[IDX_W-1:0];
      ord_wr_en     = 1'b0;
      ord_wr_addr   = k_ff[IDX_W-1:0];
      ord_wr_data   = sc_best_idx;
      ord_rd_en     = 1'b0;
      ord_rd_addr   = out_src[IDX_W-1:0];
      sc_ctrl.clear  = 1'b0;
      sc_ctrl.sample = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == mdeo_pkg::FUNC_RUN) begin
                  n_in          = n_eff;
                  active_in     = active_new;
                  placed_in     = '0;
                  j_in          = '0;
                  k_in          = '0;
                  sc_ctrl.clear = 1'b1;
                  if (n_eff == '0) begin
                     row_valid_in = '0;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else if (edge_ok) begin
                  ia_in       = a_less[IDX_W-1:0];
                  ib_in       = b_less[IDX_W-1:0];
                  adj_rd_en   = 1'b1;
                  adj_rd_addr = a_less[IDX_W-1:0];
                  state_in    = S_EDGE_A;
               end
            end
         end

         S_EDGE_A: begin
            adj_wr_en           = 1'b1;
            adj_wr_addr         = ia_ff;
            adj_wr_data         = row_q | (MAX_VERTICES'(1) << ib_ff);
            row_valid_in[ia_ff] = 1'b1;
            adj_rd_en           = 1'b1;
            adj_rd_addr         = ib_ff;
            state_in            = S_EDGE_B;
         end

         S_EDGE_B: begin
            adj_wr_en           = 1'b1;
            adj_wr_addr         = ib_ff;
            adj_wr_data         = row_q | (MAX_VERTICES'(1) << ia_ff);
            row_valid_in[ib_ff] = 1'b1;
            state_in            = S_IDLE;
         end

         S_SCAN: begin
            sc_ctrl.sample = rd_pend_ff && !placed_ff[rd_idx_ff];
            if (j_ff < n_ff) begin
               adj_rd_en   = 1'b1;
               adj_rd_addr = j_ff[IDX_W-1:0];
               rd_pend_in  = 1'b1;
               rd_idx_in   = j_ff[IDX_W-1:0];
               j_in        = j_ff + CNT_W'(1);
            end else if (scan_done) begin
               // record the winner and detach it; its row reads as empty from now
               best_in                   = sc_best_idx;
               placed_in                 = placed_ff | vbit_new;
               nb_in                     = sc_best_row & ~vbit_new;
               ord_wr_en                 = 1'b1;
               row_valid_in[sc_best_idx] = 1'b0;
               j_in                      = '0;
               state_in                  = S_UPDATE;
            end
         end

         S_UPDATE: begin
            if (rd_pend_ff) begin
               adj_wr_en               = 1'b1;
               adj_wr_addr             = rd_idx_ff;
               adj_wr_data             = (row_q | (nb_ff & ~ubit)) & ~vbit;
               row_valid_in[rd_idx_ff] = 1'b1;
            end
            if (j_ff < n_ff) begin
               if (nb_ff[j_ff[IDX_W-1:0]]) begin
                  adj_rd_en   = 1'b1;
                  adj_rd_addr = j_ff[IDX_W-1:0];
                  rd_pend_in  = 1'b1;
                  rd_idx_in   = j_ff[IDX_W-1:0];
               end
               j_in = j_ff + CNT_W'(1);
            end else if (!rd_pend_ff) begin
               if (k_ff == n_ff - CNT_W'(1)) begin
                  k_in     = '0;
                  state_in = S_OUT_READ;
               end else begin
                  k_in          = k_ff + CNT_W'(1);
                  j_in          = '0;
                  sc_ctrl.clear = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end

         S_OUT_READ: begin
            ord_rd_en = 1'b1;
            state_in  = S_OUT_LOAD;
         end

         S_OUT_LOAD: begin
            rsp_vertex_in = VTX_W'(ord_rd_data) + VTX_W'(1);
            rsp_last_in   = (k_ff == n_ff - CNT_W'(1));
            rsp_valid_in  = 1'b1;
            state_in      = S_OUT_SEND;
         end

         S_OUT_SEND: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  row_valid_in = '0;
                  state_in     = S_IDLE;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = S_OUT_READ;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         num_vertices_ff <= VTX_W'(MAX_VERTICES);
         row_valid_ff    <= '0;
         rd_pend_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            num_vertices_ff <= csr_wr_data;
         end
      end
      n_ff          <= n_in;
      active_ff     <= active_in;
      placed_ff     <= placed_in;
      nb_ff         <= nb_in;
      best_ff       <= best_in;
      ia_ff         <= ia_in;
      ib_ff         <= ib_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      if (adj_rd_en) begin
         rd_valid_ff <= row_valid_ff[adj_rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mdeo_pkg::RSP_TDATA_W'(rsp_vertex_ff);
   assign rsp_tlast  = rsp_last_ff;

   `MDEO_ASSERT_IMP(a_no_input_while_output, rsp_tvalid, !req_tready, "input taken during output")
   `MDEO_ASSERT_NXT(a_matrix_empty_after_run, rsp_tvalid && rsp_tready && rsp_tlast, row_valid_ff == '0, "matrix not cleared after run")
   `MDEO_ASSERT_IMP(a_update_drops_vertex, (state_ff == S_UPDATE) && adj_wr_en, (adj_wr_data & vbit) == '0, "eliminated vertex left in a row")
   `MDEO_ASSERT_IMP(a_scan_finds_vertex, (state_ff == S_SCAN) && scan_done, sc_stat.found, "scan ended without a candidate")

endmodule

FILE: rtl/mdeo_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mdeo_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/mdeo_scan_unit.sv
// shared degree unit: counts the live neighbors of one row per cycle and
// keeps the row of smallest degree, lowest index on ties; uses mdeo_pkg
module mdeo_scan_unit #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mdeo_pkg::scan_ctrl_type           ctrl,
   input  logic [$clog2(MAX_VERTICES)-1:0]   idx,
   input  logic [MAX_VERTICES-1:0]           row,
   output mdeo_pkg::scan_stat_type           stat,
   output logic [$clog2(MAX_VERTICES)-1:0]   best_idx,
   output logic [MAX_VERTICES-1:0]           best_row
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int NB    = (MAX_VERTICES + 7) / 8;

   logic [NB*8-1:0]                   row_pad;
   logic [mdeo_pkg::BYTE_CNT_W-1:0]   byte_cnt [NB];
   logic [CNT_W-1:0]                  deg_sum;

   logic                              s1_valid_ff;
   logic [IDX_W-1:0]                  s1_idx_ff;
   logic [MAX_VERTICES-1:0]           s1_row_ff;
   logic [mdeo_pkg::BYTE_CNT_W-1:0]   s1_cnt_ff [NB];

   logic                              s2_valid_ff;
   logic [IDX_W-1:0]                  s2_idx_ff;
   logic [MAX_VERTICES-1:0]           s2_row_ff;
   logic [CNT_W-1:0]                  s2_deg_ff;

   logic                              found_ff;
   logic [IDX_W-1:0]                  best_idx_ff;
   logic [CNT_W-1:0]                  best_deg_ff;
   logic [MAX_VERTICES-1:0]           best_row_ff;

   // per byte population counts
   always_comb begin
      row_pad = '0;
      row_pad[MAX_VERTICES-1:0] = row;
      for (int b = 0; b < NB; b++) begin
         byte_cnt[b] = '0;
         for (int i = 0; i < 8; i++) begin
            byte_cnt[b] = byte_cnt[b] + mdeo_pkg::BYTE_CNT_W'(row_pad[b*8+i]);
         end
      end
   end

   always_comb begin
      deg_sum = '0;
      for (int b = 0; b < NB; b++) begin
         deg_sum = deg_sum + CNT_W'(s1_cnt_ff[b]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= ctrl.sample;
         s2_valid_ff <= s1_valid_ff;
         // strict compare keeps the lowest index on ties
         if (s2_valid_ff && (!found_ff || (s2_deg_ff < best_deg_ff))) begin
            found_ff <= 1'b1;
         end
      end
      s1_idx_ff <= idx;
      s1_row_ff <= row;
      s1_cnt_ff <= byte_cnt;
      s2_idx_ff <= s1_idx_ff;
      s2_row_ff <= s1_row_ff;
      s2_deg_ff <= deg_sum;
      if (s2_valid_ff && (!found_ff || (s2_deg_ff < best_deg_ff))) begin
         best_idx_ff <= s2_idx_ff;
         best_deg_ff <= s2_deg_ff;
         best_row_ff <= s2_row_ff;
      end
   end

   assign stat.busy  = s1_valid_ff | s2_valid_ff;
   assign stat.found = found_ff;
   assign best_idx   = best_idx_ff;
   assign best_row   = best_row_ff;

endmodule

FILE: tb/sv/tb_min_degree_elimination_order_top.sv
`timescale 1ns / 100ps
// testbench of min_degree_elimination_order_top: streams edge and run words,
// predicts the reversed minimum degree order and checks every response word
// depends on mdeo_pkg and the block rtl
module tb_min_degree_elimination_order_top;

   localparam int   MAX_VTX     = 64;
   localparam int   VTX_W       = mdeo_pkg::VTX_W;
   localparam int   DRAIN_CYC   = 300;
   localparam int   CYCLE_LIMIT = 1000000;
   localparam int   RAND_WORDS  = 250;
   localparam int   QUIET_AFTER = 215;
   localparam bit   CFG = 1'b1;
   localparam bit   WRD = 1'b0;
   localparam logic F_ADD = mdeo_pkg::FUNC_ADD_EDGE;
   localparam logic F_RUN = mdeo_pkg::FUNC_RUN;

   typedef struct packed {
      logic [VTX_W-1:0] vertex;
      logic             last;
   } order_word_type;

   // one directed row: a register write or a request word
   typedef struct packed {
      bit               is_cfg;
      logic             func;
      logic [VTX_W-1:0] a;
      logic [VTX_W-1:0] b;
      logic [VTX_W-1:0] first_vtx;   // typed first result, 0 leaves it to the predictor
   } stim_row_type;

   localparam int N_DIR = 35;
   localparam stim_row_type DIR_ROWS [N_DIR] = '{
      '{WRD, F_RUN, 7'd0,   7'd0,   7'd64},  // empty graph at reset count
      '{CFG, F_ADD, 7'd5,   7'd0,   7'd0},
      '{WRD, F_ADD, 7'd1,   7'd2,   7'd0},
      '{WRD, F_ADD, 7'd2,   7'd3,   7'd0},
      '{WRD, F_ADD, 7'd3,   7'd3,   7'd0},   // self loop
      '{WRD, F_ADD, 7'd0,   7'd4,   7'd0},   // vertex zero
      '{WRD, F_ADD, 7'd4,   7'd6,   7'd0},   // above count
      '{WRD, F_ADD, 7'd127, 7'd1,   7'd0},
      '{WRD, F_ADD, 7'd1,   7'd127, 7'd0},
      '{WRD, F_ADD, 7'd2,   7'd0,   7'd0},
      '{WRD, F_ADD, 7'd5,   7'd4,   7'd0},
      '{WRD, F_RUN, 7'd0,   7'd0,   7'd0},
      '{CFG, F_ADD, 7'd0,   7'd0,   7'd0},   // zero vertices
      '{WRD, F_ADD, 7'd1,   7'd2,   7'd0},
      '{WRD, F_RUN, 7'd0,   7'd0,   7'd0},
      '{CFG, F_ADD, 7'd127, 7'd0,   7'd0},   // saturates
      '{WRD, F_ADD, 7'd64,  7'd1,   7'd0},
      '{WRD, F_ADD, 7'd63,  7'd64,  7'd0},
      '{WRD, F_ADD, 7'd1,   7'd63,  7'd0},
      '{WRD, F_ADD, 7'd65,  7'd2,   7'd0},
      '{WRD, F_RUN, 7'd127, 7'd127, 7'd0},
      '{CFG, F_ADD, 7'd8,   7'd0,   7'd0},
      '{WRD, F_ADD, 7'd7,   7'd8,   7'd0},
      '{WRD, F_ADD, 7'd1,   7'd8,   7'd0},
      '{CFG, F_ADD, 7'd3,   7'd0,   7'd0},   // lowered after loading
      '{WRD, F_ADD, 7'd1,   7'd2,   7'd0},
      '{WRD, F_RUN, 7'd0,   7'd0,   7'd0},
      '{CFG, F_ADD, 7'd8,   7'd0,   7'd0},
      '{WRD, F_RUN, 7'd0,   7'd0,   7'd8},   // stale edges must be gone
      '{CFG, F_ADD, 7'd1,   7'd0,   7'd0},
      '{WRD, F_ADD, 7'd1,   7'd1,   7'd0},
      '{WRD, F_RUN, 7'd0,   7'd0,   7'd1},
      '{CFG, F_ADD, 7'd2,   7'd0,   7'd0},
      '{WRD, F_ADD, 7'd2,   7'd1,   7'd0},
      '{WRD, F_RUN, 7'd0,   7'd0,   7'd2}
   };

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_tvalid  = 1'b0;
   logic                             req_tready;
   logic [mdeo_pkg::REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [0:0]                       req_tuser   = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   logic [mdeo_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;
   logic                             csr_wr_en   = 1'b0;
   logic [VTX_W-1:0]                 csr_wr_data = '0;

   // predictor state
   logic [MAX_VTX-1:0] adj_rows [MAX_VTX];
   logic [VTX_W-1:0]   vtx_count;
   order_word_type     order_q [$];
   order_word_type     want;
   logic [VTX_W-1:0]   typed_first = '0;
   bit                 quiet = 1'b0;
   int                 err_cnt = 0;
   int                 cycle_cnt = 0;

   min_degree_elimination_order_top #(
      .MAX_VERTICES(MAX_VTX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int vtx_limit();
      return (vtx_count > MAX_VTX) ? MAX_VTX : int'(vtx_count);
   endfunction

   function automatic void load_edge(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b);
      int n;
      n = vtx_limit();
      if (a >= 1 && a <= n && b >= 1 && b <= n && a != b) begin
         adj_rows[a-1][b-1] = 1'b1;
         adj_rows[b-1][a-1] = 1'b1;
      end
   endfunction

   // greedy min degree elimination, queues the order last eliminated first
   function automatic void eliminate_all(input logic [VTX_W-1:0] lead);
      int n, best, best_deg, deg;
      logic [MAX_VTX-1:0] active, gone, nbrs;
      logic [5:0] seq [MAX_VTX];
      order_word_type w;
      n = vtx_limit();
      active = (n == MAX_VTX) ? '1 : ((64'd1 << n) - 64'd1);
      gone = '0;
      for (int k = 0; k < n; k++) begin
         best = 0;
         best_deg = n + 1;
         for (int j = 0; j < n; j++) begin
            if (!gone[j]) begin
               deg = $countones(adj_rows[j] & active & ~gone);
               if (deg < best_deg) begin
                  best_deg = deg;
                  best = j;
               end
            end
         end
         seq[k] = best[5:0];
         gone[best] = 1'b1;
         nbrs = adj_rows[best] & active & ~gone;
         // fill-in: neighbors become a clique, the vertex drops out
         for (int j = 0; j < n; j++) begin
            if (nbrs[j]) begin
               adj_rows[j] = (adj_rows[j] | (nbrs & ~(64'd1 << j))) & ~(64'd1 << best);
            end
         end
         adj_rows[best] = '0;
      end
      for (int k = 0; k < n; k++) begin
         w.vertex = {1'b0, seq[n-1-k]} + 7'd1;
         w.last = (k == n - 1);
         if (k == 0 && lead != '0) w.vertex = lead;
         order_q.push_back(w);
      end
      for (int r = 0; r < MAX_VTX; r++) adj_rows[r] = '0;
   endfunction

   // predictor and response checker
   always @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAX_VTX; r++) adj_rows[r] = '0;
         vtx_count = 7'(MAX_VTX);
      end else begin
         if (csr_wr_en) vtx_count = csr_wr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == F_RUN) eliminate_all(typed_first);
            else load_edge(req_tdata[6:0], req_tdata[13:7]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (order_q.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual vertex %0d last %0b",
                        $time, rsp_tdata, rsp_tlast);
               err_cnt++;
            end else begin
               want = order_q.pop_front();
               if (rsp_tdata !== {1'b0, want.vertex}) begin
                  $display("%0t: vertex mismatch, expected %0d actual %0d",
                           $time, want.vertex, rsp_tdata);
                  err_cnt++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last mismatch, expected %0b actual %0b",
                           $time, want.last, rsp_tlast);
                  err_cnt++;
               end
            end
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            hold = $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic func, input logic [VTX_W-1:0] a,
                            input logic [VTX_W-1:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {2'b00, b, a};
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      while (order_q.size() != 0) @(negedge clock);
   endtask

   // register write only once the block has gone quiet
   task automatic write_count(input int value);
      wait_results();
      repeat (DRAIN_CYC) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[VTX_W-1:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int rand_words, big_runs, count, eff, n_edges, pick;
      rand_words = 0;
      big_runs = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_DIR; i++) begin
         if (DIR_ROWS[i].is_cfg) begin
            write_count(DIR_ROWS[i].a);
         end else begin
            typed_first = DIR_ROWS[i].first_vtx;
            send_word(DIR_ROWS[i].func, DIR_ROWS[i].a, DIR_ROWS[i].b);
            typed_first = '0;
         end
      end

      // random graphs, mostly small, a few at full size
      while (rand_words < RAND_WORDS) begin
         if (rand_words >= QUIET_AFTER) quiet = 1'b1;
         pick = $urandom_range(0, 15);
         if (pick == 0 && big_runs < 3) begin
            big_runs++;
            count = $urandom_range(0, 1) ? MAX_VTX : $urandom_range(65, 127);
         end else if (pick == 1) begin
            count = $urandom_range(0, 1);
         end else begin
            count = $urandom_range(2, 12);
         end
         write_count(count);
         eff = (count > MAX_VTX) ? MAX_VTX : count;
         n_edges = $urandom_range(0, (eff < 2) ? 3 : ((2 * eff > 24) ? 24 : 2 * eff));
         for (int e = 0; e < n_edges; e++) begin
            if (eff > 0 && $urandom_range(0, 6) != 0) begin
               send_word(F_ADD, 7'($urandom_range(1, eff)), 7'($urandom_range(1, eff)));
            end else begin
               send_word(F_ADD, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            end
            rand_words++;
         end
         if (eff > 2 && $urandom_range(0, 7) == 0) write_count($urandom_range(1, eff - 1));
         send_word(F_RUN, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
         rand_words++;
         // back to back run on the emptied matrix
         if ($urandom_range(0, 5) == 0) begin
            send_word(F_RUN, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            rand_words++;
         end
         if ($urandom_range(0, 3) == 0) wait_results();
      end

      quiet = 1'b1;
      wait_results();
      repeat (DRAIN_CYC) @(negedge clock);
      if (order_q.size() != 0) begin
         $display("%0t: %0d words still expected, actual none", $time, order_q.size());
         err_cnt++;
      end
      if (err_cnt == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: min_degree_elimination_order_top.f
+incdir+rtl
rtl/mdeo_pkg.sv
rtl/mdeo_ram.sv
rtl/mdeo_scan_unit.sv
rtl/min_degree_elimination_order_top.sv
tb/sv/tb_min_degree_elimination_order_top.sv
